@@ hw/rtl/wred_drop_decider_assert.svh @@
// Assertion macros for the WRED drop decider.
// WDD_ASSERT checks a property on every rising clock edge outside reset;
// WDD_NEVER checks that a condition never holds.
`ifndef WRED_DROP_DECIDER_ASSERT_SVH
`define WRED_DROP_DECIDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WDD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("wred_drop_decider check failed");
`define WDD_NEVER(lbl, clk, rst_n, cond) `WDD_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define WDD_ASSERT(lbl, clk, rst_n, prop)
`define WDD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/wdd_pkg.sv @@
package wdd_pkg;

	localparam int QLEN_W = 16;
	localparam int RAND_W = 16;
	localparam int FRAC_W = 16;
	localparam int PROB_W = 17;
	localparam int PCT_W = 7;
	localparam int NUM_W = 39;   // widest dividend: 100 * 2^32 and 127 * 2^32 both fit
	localparam int DIV_W = 23;   // widest divisor: 65535 * 100
	localparam int STEP_W = 6;
	localparam int CFG_IDX_W = 8;

	localparam logic [PCT_W-1:0] PERCENT = 7'd100;
	localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [STEP_W-1:0] AVG_STEPS = 6'd32;
	localparam logic [STEP_W-1:0] PROB_STEPS = 6'd17;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_TH = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TH = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_P = 8'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULA,
		ST_MULB,
		ST_SD1,
		ST_DIV1,
		ST_CMP,
		ST_MUL2,
		ST_CHK,
		ST_DIV2,
		ST_FIN
	} wdd_state_t;

	// Request to the serial divider: rem_init must be below divisor.
	typedef struct packed {
		logic start;
		logic [STEP_W-1:0] steps;
		logic [DIV_W-1:0] rem_init;
		logic [31:0] bits;
		logic [DIV_W-1:0] divisor;
	} wdd_div_req_t;

	typedef struct packed {
		logic done;
		logic busy;
	} wdd_div_sts_t;

endpackage

@@ hw/rtl/wdd_if.sv @@
interface wdd_in_if;
	import wdd_pkg::*;
	logic valid;
	logic ready;
	logic [QLEN_W-1:0] queue_len;
	logic [RAND_W-1:0] random_value;
	modport source (output valid, output queue_len, output random_value, input ready);
	modport sink (input valid, input queue_len, input random_value, output ready);
endinterface

interface wdd_out_if;
	import wdd_pkg::*;
	logic valid;
	logic ready;
	logic drop;
	logic [15:0] avg_len;
	logic [PROB_W-1:0] drop_chance;
	modport source (output valid, output drop, output avg_len, output drop_chance, input ready);
	modport sink (input valid, input drop, input avg_len, input drop_chance, output ready);
endinterface

interface wdd_cfg_if;
	import wdd_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/wred_drop_decider.sv @@
// WRED drop decider.
// req (sink): one beat per packet arrival with queue_len and random_value.
// rsp (source): one beat per request with drop, avg_len (integer part of
//   the new 16.16 average) and drop_chance (Q1.16, 0x10000 = certain).
// cfg (sink): register writes, index 0 min threshold, 1 max threshold,
//   2 weight percent, 3 max probability percent; always ready, and only
//   to be written while no packet is in flight. Other indexes are ignored.
// One packet at a time: req.ready is high only while idle. A new beat can be
//   taken in the cycle rsp.valid rises. Both divisions run on the shared
//   bit-serial divider: the average (divide by 100) and the linear
//   probability (divide by the threshold span times 100, or by 100 when the
//   thresholds are equal), with multiply and compare steps around them. The
//   second division is skipped when the average lies outside the thresholds
//   or the linear part is certain to saturate.
// The result sits in an output register; if rsp stalls, the next packet's
//   work runs to the end and then waits until the held beat is taken.
// Reset clears the average to zero and loads the default thresholds
//   (64, 192), weight 2 and max probability 10.
`include "wred_drop_decider_assert.svh"
module wred_drop_decider
	import wdd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	wdd_in_if.sink req,
	wdd_out_if.source rsp,
	wdd_cfg_if.sink cfg
);

	// configuration
	logic [15:0] min_th_q;
	logic [15:0] max_th_q;
	logic [PCT_W-1:0] weight_q;
	logic [PCT_W-1:0] max_p_q;

	// control
	wdd_state_t state_q, state_d;
	logic out_valid_q;
	logic [31:0] avg_q;

	// datapath
	logic [QLEN_W-1:0] qlen_q;
	logic [RAND_W-1:0] rnd_q;
	logic [NUM_W-1:0] num_q;
	logic [DIV_W-1:0] dvs_q;
	logic [31:0] excess_q;
	logic [PROB_W-1:0] prob_q;
	logic out_drop_q;
	logic [15:0] out_avg_q;
	logic [PROB_W-1:0] out_prob_q;

	wdd_div_req_t div_req;
	wdd_div_sts_t div_sts;
	logic [31:0] div_quo;

	logic req_acc;
	logic fin_load;
	logic [PCT_W-1:0] w_eff;
	logic [31:0] lo_th;
	logic [31:0] hi_th;
	logic below;
	logic above;
	logic [15:0] span;
	logic sat;

	assign req_acc = req.valid && req.ready;
	assign w_eff = (weight_q > PERCENT) ? PERCENT : weight_q;
	assign lo_th = {min_th_q, 16'd0};
	assign hi_th = {max_th_q, 16'd0};
	assign below = avg_q < lo_th;
	assign above = avg_q > hi_th;
	assign span = max_th_q - min_th_q;
	// quotient would need more than 17 bits: certainly above one
	assign sat = {1'b0, num_q} >= {dvs_q, 17'd0};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req_acc) state_d = ST_MULA;
			ST_MULA: state_d = ST_MULB;
			ST_MULB: state_d = ST_SD1;
			ST_SD1:  state_d = ST_DIV1;
			ST_DIV1: if (div_sts.done) state_d = ST_CMP;
			ST_CMP:  state_d = (below || above) ? ST_FIN : ST_MUL2;
			ST_MUL2: state_d = ST_CHK;
			ST_CHK:  state_d = sat ? ST_FIN : ST_DIV2;
			ST_DIV2: if (div_sts.done) state_d = ST_FIN;
			ST_FIN:  if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req.ready = 1'b0;
		fin_load = 1'b0;
		div_req.start = 1'b0;
		div_req.steps = AVG_STEPS;
		div_req.rem_init = DIV_W'(num_q[NUM_W-1:32]);
		div_req.bits = num_q[31:0];
		div_req.divisor = DIV_W'(PERCENT);
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SD1:  div_req.start = 1'b1;
			ST_CHK: begin
				div_req.start = !sat;
				div_req.steps = PROB_STEPS;
				div_req.rem_init = DIV_W'(num_q[NUM_W-1:17]);
				div_req.bits = {num_q[16:0], 15'd0};
				div_req.divisor = dvs_q;
			end
			ST_FIN:  fin_load = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			avg_q <= '0;
			min_th_q <= 16'd64;
			max_th_q <= 16'd192;
			weight_q <= 7'd2;
			max_p_q <= 7'd10;
		end else begin
			state_q <= state_d;
			if (fin_load)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
			if (state_q == ST_DIV1 && div_sts.done)
				avg_q <= div_quo;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_MIN_TH: min_th_q <= cfg.data;
					REG_MAX_TH: max_th_q <= cfg.data;
					REG_WEIGHT: weight_q <= cfg.data[PCT_W-1:0];
					REG_MAX_P:  max_p_q <= cfg.data[PCT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			qlen_q <= req.queue_len;
			rnd_q <= req.random_value;
		end
		case (state_q)
			// (100 - w) * avg
			ST_MULA: num_q <= NUM_W'(avg_q) * NUM_W'(PERCENT - w_eff);
			// + w * qlen * 2^16
			ST_MULB: num_q <= num_q + {(23'(qlen_q) * 23'(w_eff)), 16'd0};
			ST_CMP: begin
				excess_q <= avg_q - lo_th;
				prob_q <= below ? '0 : ONE_Q16;
			end
			ST_MUL2: begin
				if (span == 16'd0) begin
					// thresholds equal: full max probability
					num_q <= NUM_W'({max_p_q, 16'd0});
					dvs_q <= DIV_W'(PERCENT);
				end else begin
					num_q <= NUM_W'(excess_q) * NUM_W'(max_p_q);
					dvs_q <= DIV_W'(span) * DIV_W'(PERCENT);
				end
			end
			ST_CHK:  prob_q <= ONE_Q16;
			// max probability above 100 percent can overshoot one: clamp
			ST_DIV2: if (div_sts.done)
				prob_q <= (div_quo > 32'(ONE_Q16)) ? ONE_Q16 : div_quo[PROB_W-1:0];
			default: ;
		endcase
		if (fin_load) begin
			out_drop_q <= {1'b0, rnd_q} < prob_q;
			out_avg_q <= avg_q[31:16];
			out_prob_q <= prob_q;
		end
	end

	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.drop = out_drop_q;
	assign rsp.avg_len = out_avg_q;
	assign rsp.drop_chance = out_prob_q;

	wdd_serdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts),
		.quo    (div_quo)
	);

	`WDD_ASSERT(a_acc_starts, clk, arst_n, req_acc |=> state_q == ST_MULA)
	`WDD_NEVER(a_div_done_place, clk, arst_n,
		div_sts.done && !(state_q == ST_DIV1 || state_q == ST_DIV2))
	`WDD_NEVER(a_div_busy_place, clk, arst_n,
		div_sts.busy && !(state_q == ST_DIV1 || state_q == ST_DIV2))
	`WDD_ASSERT(a_prob_range, clk, arst_n, rsp.valid |-> rsp.drop_chance <= ONE_Q16)
	`WDD_ASSERT(a_drop_needs_prob, clk, arst_n, (rsp.valid && rsp.drop) |-> rsp.drop_chance != 0)

endmodule

@@ hw/rtl/wdd_serdiv.sv @@
// Restoring divider, one quotient bit per cycle.
module wdd_serdiv
	import wdd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  wdd_div_req_t req,
	output wdd_div_sts_t sts,
	output logic [31:0] quo
);

	logic run_q;
	logic done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;
	logic [31:0] sh_q;
	logic [DIV_W:0] trial;
	logic ge;

	assign trial = {rem_q, sh_q[31]};
	assign ge = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= run_q && (cnt_q == STEP_W'(1));
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= req.steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			sh_q <= req.bits;
			dvs_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? DIV_W'(trial - {1'b0, dvs_q}) : trial[DIV_W-1:0];
			sh_q <= {sh_q[30:0], ge};
		end
	end

	assign sts.done = done_q;
	assign sts.busy = run_q;
	assign quo = sh_q;

endmodule
